FILE: rtl/core/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

	localparam int WORD_W    = 32;
	localparam int CMD_W     = 3;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_LEFT  = 3'd0,
		CMD_PUSH_RIGHT = 3'd1,
		CMD_POP_LEFT   = 3'd2,
		CMD_REMOVE     = 3'd3,
		CMD_MIN        = 3'd4,
		CMD_MAX        = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} stat_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		stat_t                    status;
		logic [CNT_OUT_W-1:0]     count;
	} bdq_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/bdq_engine.sv
`default_nettype none

module bdq_engine import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic signed [WORD_W-1:0] value,
	output      logic                     idle,
	input  wire logic                     res_ready,
	output      logic                     res_valid,
	output      bdq_result_t              res
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [PTR_W-1:0]         head_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         idx_q;
	cmd_t                     cmd_q;
	logic signed [WORD_W-1:0] val_q;
	logic signed [WORD_W-1:0] res_q;
	stat_t                    stat_q;

	// ring storage, one write and one registered read per cycle
	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rdata_q;
	logic [PTR_W-1:0]         raddr;
	logic [PTR_W-1:0]         waddr;
	logic signed [WORD_W-1:0] wdata;
	logic                     we;

	logic [CNT_W-1:0]         rd_l;
	logic [PTR_W-1:0]         head_dec;
	logic [PTR_W-1:0]         head_inc;
	logic                     full;
	logic                     empty;
	logic                     is_last;
	logic                     take;
	cmd_t                     cmd_in;

	// logical position -> ring address
	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] h,
			input logic [CNT_W-1:0] l);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	assign cmd_in   = cmd_t'(command);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign is_last  = (idx_q == count_q - CNT_W'(1));
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	// read one position ahead of the entry being examined
	assign rd_l  = (state_q == S_IDLE) ? '0 : idx_q + CNT_W'(1);
	assign raddr = phys(head_q, rd_l);

	always_comb begin
		we    = 1'b0;
		waddr = phys(head_q, count_q);
		wdata = value;
		if (state_q == S_IDLE && start && !full) begin
			if (cmd_in == CMD_PUSH_LEFT) begin
				we    = 1'b1;
				waddr = head_dec;
			end else if (cmd_in == CMD_PUSH_RIGHT) begin
				we    = 1'b1;
			end
		end else if (state_q == S_SHIFT) begin
			// entry idx moves down to idx-1
			we    = 1'b1;
			waddr = phys(head_q, idx_q - CNT_W'(1));
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		if (idx_q == '0) begin
			take = 1'b1;
		end else if (cmd_q == CMD_MIN) begin
			take = rdata_q < res_q;
		end else begin
			take = res_q < rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			cmd_q   <= CMD_PUSH_LEFT;
			val_q   <= '0;
			res_q   <= '0;
			stat_q  <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_in;
						val_q   <= value;
						res_q   <= '0;
						stat_q  <= STAT_OK;
						idx_q   <= '0;
						state_q <= S_DONE;
						unique case (cmd_in)
							CMD_PUSH_LEFT: begin
								if (full) begin
									stat_q <= STAT_FULL;
								end else begin
									head_q  <= head_dec;
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_PUSH_RIGHT: begin
								if (full) begin
									stat_q <= STAT_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_POP_LEFT, CMD_REMOVE, CMD_MIN, CMD_MAX: begin
								if (empty) begin
									stat_q <= STAT_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					case (cmd_q)
						CMD_POP_LEFT: begin
							res_q   <= rdata_q;
							head_q  <= head_inc;
							count_q <= count_q - CNT_W'(1);
							state_q <= S_DONE;
						end
						CMD_REMOVE: begin
							if (rdata_q == val_q) begin
								if (is_last) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= S_DONE;
								end else begin
									idx_q   <= idx_q + CNT_W'(1);
									state_q <= S_SHIFT;
								end
							end else if (is_last) begin
								stat_q  <= STAT_NOT_FOUND;
								state_q <= S_DONE;
							end else begin
								idx_q <= idx_q + CNT_W'(1);
							end
						end
						default: begin
							if (take) begin
								res_q <= rdata_q;
							end
							if (is_last) begin
								state_q <= S_DONE;
							end else begin
								idx_q <= idx_q + CNT_W'(1);
							end
						end
					endcase
				end
				S_SHIFT: begin
					if (is_last) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.value  = res_q;
	assign res.status = stat_q;
	assign res.count  = CNT_OUT_W'(count_q);

endmodule

`default_nettype wire

FILE: rtl/core/bounded_deque_with_min_max.sv
// Bounded double-ended list of signed 32-bit values with min/max query.
// Input channel (in_valid/in_ready): one command per transaction, with a
//   value for push and remove. Output channel (out_valid/out_ready): exactly
//   one result per command: value, status and the entry count afterwards.
// Storage is a ring of DEPTH words in a synchronous RAM with a head pointer;
//   pushes write one word, pop reads the head, remove/min/max walk the ring
//   one read per cycle, and remove moves each word past the match down one
//   position in the same walk, so it never takes longer than the scan.
// The engine steps through its states in order: pushes, errors and unused
//   codes go straight to done, pop reads the head first, and min, max and
//   remove on a non-empty list walk every entry, paced by the single RAM
//   read port. One command is in flight at a time; in_ready returns the cycle
//   after the result leaves the engine, so none is taken while one is inside.
// Results land in an output register, so the next command is accepted while
//   a result waits; an engine that finishes while that register is still
//   full holds its result until the receiver takes the pending one.
// Reset (arst_n low) empties the list and clears out_valid; RAM contents
//   are left as they were and are never used before being written.
`default_nettype none

module bounded_deque_with_min_max import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output      logic                     in_ready,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic signed [WORD_W-1:0] value,
	output      logic                     out_valid,
	input  wire logic                     out_ready,
	output      logic signed [WORD_W-1:0] result_value,
	output      logic [STAT_W-1:0]        status,
	output      logic [CNT_OUT_W-1:0]     entry_count
);

	logic        eng_idle;
	logic        eng_valid;
	logic        eng_ready;
	bdq_result_t eng_res;
	logic        out_valid_q;
	bdq_result_t out_q;

	bdq_engine #(
		.DEPTH(DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && eng_idle),
		.command  (command),
		.value    (value),
		.idle     (eng_idle),
		.res_ready(eng_ready),
		.res_valid(eng_valid),
		.res      (eng_res)
	);

	assign in_ready  = eng_idle;
	// output register is free, or drains this cycle
	assign eng_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_valid && eng_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid && eng_ready) begin
			out_q <= eng_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_q.value;
	assign status       = out_q.status;
	assign entry_count  = out_q.count;

endmodule

`default_nettype wire
